[design/pfe_pkg.sv]
// ----------------------------------------------------------------------------
// Playfair encryption stream package
// Shared constants, the command passed from the front to the back, and the
// small helpers for row and column arithmetic on the 5x5 square.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int SIDE        = 5;
  localparam int CELLS       = 25;
  localparam int LETTERS     = 26;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [4:0] LETTER_Q   = 5'd16;
  localparam logic [4:0] LETTER_X   = 5'd23;
  localparam logic [4:0] SPACE_CODE = 5'd26;

  // Input operation codes.
  localparam logic [1:0] OP_KEY    = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_TEXT   = 2'd2;
  localparam logic [1:0] OP_END    = 2'd3;

  typedef enum logic [1:0] {
    CMD_KEY,
    CMD_FILL,
    CMD_PAIR,
    CMD_BAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [4:0] a;
    logic [4:0] b;
  } cmd_t;

  // Next row or column, wrapping around the square.
  function automatic logic [2:0] wrap_inc(input logic [2:0] v);
    logic [2:0] r;
    if (v == 3'(SIDE - 1)) begin
      r = 3'd0;
    end else begin
      r = v + 3'd1;
    end
    return r;
  endfunction

  // Cell address from row and column: row * 5 + col.
  function automatic logic [4:0] cell_index(input logic [2:0] row, input logic [2:0] col);
    return {row, 2'b00} + 5'(row) + 5'(col);
  endfunction

endpackage

[design/pfe_front.sv]
// ----------------------------------------------------------------------------
// Playfair front end
// Accepts input items, tracks key completion and the pending text letter,
// and turns each item into at most one command for the back end.
// ----------------------------------------------------------------------------
module pfe_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [1:0]    op,
  input  logic [4:0]    letter,
  input  logic          full,
  output logic          push,
  output pfe_pkg::cmd_t cmd
);

  logic       key_ready;
  logic       pending_valid;
  logic [4:0] pending_letter;
  logic       accept;

  assign accept = in_valid && !full;

  always_comb begin
    cmd.kind = pfe_pkg::CMD_KEY;
    cmd.a    = letter;
    cmd.b    = 5'd0;
    push     = 1'b0;
    case (op)
      pfe_pkg::OP_KEY: begin
        push = !key_ready && (letter < pfe_pkg::SPACE_CODE) && (letter != pfe_pkg::LETTER_Q);
      end
      pfe_pkg::OP_FINISH: begin
        cmd.kind = pfe_pkg::CMD_FILL;
        push     = !key_ready;
      end
      pfe_pkg::OP_TEXT: begin
        if (letter < pfe_pkg::SPACE_CODE) begin
          if (!key_ready || letter == pfe_pkg::LETTER_Q) begin
            cmd.kind = pfe_pkg::CMD_BAD;
            push     = 1'b1;
          end else if (pending_valid) begin
            cmd.kind = pfe_pkg::CMD_PAIR;
            push     = 1'b1;
            if (pending_letter == letter) begin
              cmd.b = pfe_pkg::LETTER_X;
            end else begin
              cmd.a = pending_letter;
              cmd.b = letter;
            end
          end
        end
      end
      pfe_pkg::OP_END: begin
        cmd.kind = pfe_pkg::CMD_PAIR;
        cmd.a    = pending_letter;
        cmd.b    = pfe_pkg::LETTER_X;
        push     = key_ready && pending_valid;
      end
      default: begin
        push = 1'b0;
      end
    endcase
    push = push && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_ready      <= 1'b0;
      pending_valid  <= 1'b0;
      pending_letter <= 5'd0;
    end else if (accept) begin
      case (op)
        pfe_pkg::OP_FINISH: begin
          key_ready <= 1'b1;
        end
        pfe_pkg::OP_TEXT: begin
          if (letter < pfe_pkg::SPACE_CODE && key_ready && letter != pfe_pkg::LETTER_Q) begin
            if (!pending_valid) begin
              pending_letter <= letter;
              pending_valid  <= 1'b1;
            end else if (pending_letter != letter) begin
              pending_valid <= 1'b0;
            end
          end
        end
        pfe_pkg::OP_END: begin
          if (key_ready) begin
            pending_valid <= 1'b0;
          end
        end
        default: begin
          pending_valid <= pending_valid;
        end
      endcase
    end
  end

endmodule

[design/pfe_queue.sv]
// ----------------------------------------------------------------------------
// Playfair command queue
// A small first-in first-out buffer of commands between front and back.
// ----------------------------------------------------------------------------
module pfe_queue #(
  parameter int DEPTH = pfe_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pfe_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output pfe_pkg::cmd_t pop_data,
  output logic          not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pfe_pkg::cmd_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> (!full || pop))
    else $error("command pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("command popped from an empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

[design/pfe_back.sv]
// ----------------------------------------------------------------------------
// Playfair back end
// Builds the key square, enciphers digraphs from the square memories and
// drives the result register.
// ----------------------------------------------------------------------------
module pfe_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  pfe_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [4:0]    cipher_letter,
  output logic          pair_end,
  output logic          bad_letter
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_SEND,
    S_FILL
  } state_t;

  state_t state;

  // Square contents and the {row, col} position of every placed letter.
  logic [4:0] sq_mem  [pfe_pkg::CELLS];
  logic [5:0] pos_mem [pfe_pkg::LETTERS];

  logic [pfe_pkg::LETTERS-1:0] used;
  logic [4:0] fill_count;
  logic [2:0] fill_row;
  logic [2:0] fill_col;
  logic [4:0] iter;
  logic       send_bad;
  logic       send_second;
  logic [5:0] pa;
  logic [5:0] pb;
  logic [4:0] sx;
  logic [4:0] sy;

  logic       place_en;
  logic [4:0] place_letter;
  logic       pos_rd;
  logic       out_free;
  logic [2:0] xr, xc, yr, yc;
  logic [4:0] addr_x;
  logic [4:0] addr_y;

  assign cmd_pop      = (state == S_IDLE) && cmd_valid;
  assign place_letter = (state == S_FILL) ? iter : cmd.a;
  assign place_en     = (fill_count < 5'(pfe_pkg::CELLS)) && !used[place_letter] &&
                        ((cmd_pop && cmd.kind == pfe_pkg::CMD_KEY) ||
                         (state == S_FILL && iter != pfe_pkg::LETTER_Q));
  assign pos_rd       = cmd_pop && cmd.kind == pfe_pkg::CMD_PAIR;
  assign out_free     = !out_valid || !out_stall;

  // Playfair rules on the looked-up positions.
  always_comb begin
    if (pa[5:3] == pb[5:3]) begin
      xr = pa[5:3];
      xc = pfe_pkg::wrap_inc(pa[2:0]);
      yr = pb[5:3];
      yc = pfe_pkg::wrap_inc(pb[2:0]);
    end else if (pa[2:0] == pb[2:0]) begin
      xr = pfe_pkg::wrap_inc(pa[5:3]);
      xc = pa[2:0];
      yr = pfe_pkg::wrap_inc(pb[5:3]);
      yc = pb[2:0];
    end else begin
      xr = pa[5:3];
      xc = pb[2:0];
      yr = pb[5:3];
      yc = pa[2:0];
    end
    addr_x = pfe_pkg::cell_index(xr, xc);
    addr_y = pfe_pkg::cell_index(yr, yc);
  end

  always_ff @(posedge clk) begin
    if (place_en) begin
      sq_mem[fill_count]    <= place_letter;
      pos_mem[place_letter] <= {fill_row, fill_col};
    end
    if (pos_rd) begin
      pa <= pos_mem[cmd.a];
      pb <= pos_mem[cmd.b];
    end
    if (state == S_LOOKUP) begin
      sx <= sq_mem[addr_x];
      sy <= sq_mem[addr_y];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used       <= '0;
      fill_count <= 5'd0;
      fill_row   <= 3'd0;
      fill_col   <= 3'd0;
      out_valid  <= 1'b0;
    end else begin
      // In the send step the result register is reloaded below instead.
      if (out_valid && !out_stall && state != S_SEND) begin
        out_valid <= 1'b0;
      end
      if (place_en) begin
        used[place_letter] <= 1'b1;
        fill_count         <= fill_count + 5'd1;
        if (fill_col == 3'(pfe_pkg::SIDE - 1)) begin
          fill_col <= 3'd0;
          fill_row <= fill_row + 3'd1;
        end else begin
          fill_col <= fill_col + 3'd1;
        end
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            case (cmd.kind)
              pfe_pkg::CMD_FILL: begin
                iter  <= 5'd0;
                state <= S_FILL;
              end
              pfe_pkg::CMD_PAIR: begin
                send_bad    <= 1'b0;
                send_second <= 1'b0;
                state       <= S_LOOKUP;
              end
              pfe_pkg::CMD_BAD: begin
                send_bad    <= 1'b1;
                send_second <= 1'b0;
                state       <= S_SEND;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_LOOKUP: begin
          state <= S_SEND;
        end
        S_SEND: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (send_bad) begin
              cipher_letter <= 5'd0;
              pair_end      <= 1'b1;
              bad_letter    <= 1'b1;
              state         <= S_IDLE;
            end else if (!send_second) begin
              cipher_letter <= sx;
              pair_end      <= 1'b0;
              bad_letter    <= 1'b0;
              send_second   <= 1'b1;
            end else begin
              cipher_letter <= sy;
              pair_end      <= 1'b1;
              bad_letter    <= 1'b0;
              state         <= S_IDLE;
            end
          end
        end
        S_FILL: begin
          iter <= iter + 5'd1;
          if (iter == 5'(pfe_pkg::LETTERS - 1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= 5'(pfe_pkg::CELLS))
    else $error("square filled beyond its cell count");
  a_bad_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_letter) |-> (pair_end && cipher_letter == 5'd0))
    else $error("flagged result with wrong fields");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (state == S_IDLE))
    else $error("command taken while busy");
`endif

endmodule

[design/playfair_encrypt_stream.sv]
// ----------------------------------------------------------------------------
// Playfair encryption stream
// Builds a 5x5 key square from key letters and enciphers text digraphs.
// ----------------------------------------------------------------------------
//  Channel  Handshake            Payload
//  input    in_valid / in_stall  op, letter
//  output   out_valid/out_stall  cipher_letter, pair_end, bad_letter
//
// A new key letter is placed as the back end takes it; finishing the key runs
// the fill sequencer over all 26 letters. A digraph goes through position lookup,
// square read, then two result transfers from the single output register.
// Reset is synchronous; the key square is rebuilt by the key letters that
// follow. in_stall rises when the command queue is full, and out_stall holds
// the back end in its send step.
// ----------------------------------------------------------------------------
module playfair_encrypt_stream #(
  parameter int QUEUE_DEPTH = pfe_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  logic [4:0] letter,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] cipher_letter,
  output logic       pair_end,
  output logic       bad_letter
);

  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_not_empty;
  pfe_pkg::cmd_t push_cmd;
  pfe_pkg::cmd_t head_cmd;

  assign in_stall = q_full;

  pfe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .letter   (letter),
    .full     (q_full),
    .push     (q_push),
    .cmd      (push_cmd)
  );

  pfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (head_cmd),
    .not_empty (q_not_empty)
  );

  pfe_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (q_not_empty),
    .cmd           (head_cmd),
    .cmd_pop       (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cipher_letter (cipher_letter),
    .pair_end      (pair_end),
    .bad_letter    (bad_letter)
  );

endmodule
